// File: hw/rtl/power_offer_decode_dedup_assert.svh
// assertion macros used by the checker file
`ifndef POWER_OFFER_DECODE_DEDUP_ASSERT_SVH
`define POWER_OFFER_DECODE_DEDUP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define POD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define POD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pod_pkg.sv
// shared types, constants and codes of the power offer decoder
package pod_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int CNT_W           = 5;
  localparam int WORD_W          = 32;
  localparam int VMAX_W          = 16;
  localparam int VMIN_W          = 15;
  localparam int AMP_W           = 22;
  localparam int SLOT_W          = 4;
  localparam int DIVIDEND_W      = 28;
  localparam int DIVISOR_W       = 16;
  localparam int DIV_CNT_W       = 5;

  localparam logic [CNT_W-1:0]      LIMIT_RESET    = 5'd16;
  localparam logic [VMAX_W-1:0]     FIX_VOLT_STEP  = 16'd50;
  localparam logic [VMAX_W-1:0]     AUG_VOLT_STEP  = 16'd100;
  localparam logic [VMIN_W-1:0]     AUG_VMIN_STEP  = 15'd100;
  localparam logic [AMP_W-1:0]      FIX_AMP_STEP   = 22'd10;
  localparam logic [AMP_W-1:0]      PROG_AMP_STEP  = 22'd50;
  localparam logic [DIVIDEND_W-1:0] WATT_SCALE     = 28'd1000000;
  localparam logic [VMIN_W-1:0]     ADJ_MIN_MV     = 15'd9000;
  localparam logic [VMAX_W-1:0]     ADJ_HIGH_MV    = 16'd20000;
  localparam logic [VMAX_W-1:0]     ADJ_LOW_MV     = 16'd15000;

  localparam logic [1:0] TYPE_AUGMENTED = 2'd3;

  typedef enum logic [1:0] {
    AUG_PROG = 2'd0,
    AUG_EXT  = 2'd1,
    AUG_STD  = 2'd2,
    AUG_RSVD = 2'd3
  } aug_t;

  typedef enum logic [1:0] {
    OUT_STORED  = 2'd0,
    OUT_INVALID = 2'd1,
    OUT_DUP     = 2'd2,
    OUT_BEYOND  = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_CHECK,
    ST_SCAN,
    ST_STORE,
    ST_FINISH
  } state_t;

  // one decoded offer, also the table entry layout
  typedef struct packed {
    logic [VMAX_W-1:0] vmax;
    logic [VMIN_W-1:0] vmin;
    logic [AMP_W-1:0]  amp;
    logic              pps;
    logic              avs;
  } offer_t;

  localparam int OFFER_W = $bits(offer_t);

  typedef struct packed {
    offer_t                o;
    logic                  need_div;
    logic [DIVIDEND_W-1:0] dividend;
  } dec_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [AMP_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: hw/rtl/power_offer_decode_dedup.sv
// power offer decoder: table-scan sequencer around the offer ram and divider
// states, request to registered result: beyond-limit idle, decode, finish; invalid adds
//   check; duplicate adds a scan, one ram read per entry up to the matching slot; stored
//   scans all entries then adds store; extended-range adds the 28-step serial divider
// one word in flight, the next request waits for idle
// reset: counts clear, parse limit returns to 16, table contents stay undefined
module power_offer_decode_dedup
  import pod_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [WORD_W-1:0]     offer_word,
  input  logic                  start_list,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            outcome,
  output logic [SLOT_W-1:0]     slot,
  output logic [VMAX_W-1:0]     max_volt_mv,
  output logic [VMIN_W-1:0]     min_volt_mv,
  output logic [AMP_W-1:0]      max_amp_ma,
  output logic                  prog_supply,
  output logic                  adj_supply,
  output logic [CNT_W-1:0]      stored_count
);

  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LIM_CAP = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;
  localparam logic [CNT_W-1:0] LIM_CAP_V = CNT_W'(LIM_CAP);

  state_t state, state_next;

  logic [CNT_W-1:0]  parse_limit;
  logic [CNT_W-1:0]  words_seen;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  pend_idx;
  logic              pend;
  logic [WORD_W-1:0] word_q;
  offer_t            offer_q;
  outcome_t          res_outcome;
  logic [SLOT_W-1:0] res_slot;

  dec_t     dec;
  div_req_t div_req;
  div_rsp_t div_rsp;
  offer_t   rd_data;
  logic     ram_we;

  logic [CNT_W-1:0] limit;
  logic             beyond;
  logic             invalid;
  logic             hit;
  logic             issue;
  logic             out_load;

  pod_decode u_decode (
    .word (word_q),
    .dec  (dec)
  );

  pod_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pod_ram #(
    .WIDTH (OFFER_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(entry_count)),
    .wdata (offer_q),
    .raddr (AW'(scan_idx)),
    .rdata (rd_data)
  );

  always_comb begin
    limit   = (parse_limit > LIM_CAP_V) ? LIM_CAP_V : parse_limit;
    beyond  = words_seen >= limit;
    invalid = offer_q.vmax == '0 || offer_q.amp == '0 ||
              ((offer_q.pps || offer_q.avs) && {1'b0, offer_q.vmin} >= offer_q.vmax);
    hit     = pend && (rd_data == offer_q);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        priority if (beyond)       state_next = ST_FINISH;
        else if (dec.need_div)     state_next = ST_DIV;
        else                       state_next = ST_CHECK;
      end
      ST_DIV:    if (div_rsp.done) state_next = ST_CHECK;
      ST_CHECK:  state_next = invalid ? ST_FINISH : ST_SCAN;
      ST_SCAN: begin
        priority if (hit)          state_next = ST_FINISH;
        else if (!issue && !pend)  state_next = ST_STORE;
        else                       state_next = ST_SCAN;
      end
      ST_STORE:  state_next = ST_FINISH;
      ST_FINISH: if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready         = state == ST_IDLE;
    cfg_ready        = 1'b1;
    div_req.start    = state == ST_DECODE && !beyond && dec.need_div;
    div_req.dividend = dec.dividend;
    div_req.divisor  = dec.o.vmax;
    issue            = state == ST_SCAN && scan_idx < entry_count && !hit;
    ram_we           = state == ST_STORE && int'(entry_count) < TABLE_DEPTH;
    out_load         = state == ST_FINISH && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      parse_limit <= LIMIT_RESET;
      words_seen  <= '0;
      entry_count <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (cfg_valid && cfg_ready) begin
        parse_limit <= cfg_data;
      end
      if (in_valid && in_ready && start_list) begin
        words_seen  <= '0;
        entry_count <= '0;
      end
      if (state == ST_DECODE && !beyond) begin
        words_seen <= words_seen + CNT_W'(1);
      end
      if (ram_we) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_q <= offer_word;
    end
    pend_idx <= scan_idx;
    unique case (state)
      ST_DECODE: begin
        offer_q     <= beyond ? '0 : dec.o;
        res_outcome <= OUT_BEYOND;
        res_slot    <= '0;
      end
      ST_DIV: begin
        if (div_rsp.done) offer_q.amp <= div_rsp.quotient;
      end
      ST_CHECK: begin
        res_outcome <= OUT_INVALID;
        scan_idx    <= '0;
      end
      ST_SCAN: begin
        if (hit) begin
          res_outcome <= OUT_DUP;
          res_slot    <= SLOT_W'(pend_idx);
        end
        if (issue) scan_idx <= scan_idx + CNT_W'(1);
      end
      ST_STORE: begin
        res_outcome <= OUT_STORED;
        res_slot    <= SLOT_W'(entry_count);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      outcome      <= res_outcome;
      slot         <= res_slot;
      max_volt_mv  <= offer_q.vmax;
      min_volt_mv  <= offer_q.vmin;
      max_amp_ma   <= offer_q.amp;
      prog_supply  <= offer_q.pps;
      adj_supply   <= offer_q.avs;
      stored_count <= entry_count;
    end
  end

endmodule

// File: hw/rtl/pod_ram.sv
// generic single-port-write, registered-read ram
module pod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pod_div.sv
// restoring divider, one quotient bit per cycle while busy
module pod_div
  import pod_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVIDEND_W-1:0] num;
  logic [DIVISOR_W-1:0]  den;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_next;

  always_comb begin
    rem_sh   = {rem, num[DIVIDEND_W-1]};
    ge       = rem_sh >= {1'b0, den};
    rem_next = ge ? DIVISOR_W'(rem_sh - {1'b0, den}) : DIVISOR_W'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // dividend bits shift out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= '0;
      num <= req.dividend;
      den <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      cnt <= cnt + DIV_CNT_W'(1);
      num <= {num[DIVIDEND_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = num[AMP_W-1:0];

endmodule

// File: hw/rtl/pod_decode.sv
// field decode of one power data object word
module pod_decode
  import pod_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  output dec_t              dec
);

  aug_t sub;

  always_comb begin
    sub = aug_t'(word[29:28]);
    dec = '0;
    if (word[31:30] != TYPE_AUGMENTED) begin
      dec.o.vmax = VMAX_W'(word[19:10] * FIX_VOLT_STEP);
      dec.o.amp  = AMP_W'(word[9:0] * FIX_AMP_STEP);
    end else begin
      unique case (sub)
        AUG_PROG: begin
          dec.o.pps  = 1'b1;
          dec.o.vmax = VMAX_W'(word[24:17] * AUG_VOLT_STEP);
          dec.o.vmin = VMIN_W'(word[15:8] * AUG_VMIN_STEP);
          dec.o.amp  = AMP_W'(word[6:0] * PROG_AMP_STEP);
        end
        AUG_EXT: begin
          // current comes later from watts * 1e6 / vmax
          dec.o.avs    = 1'b1;
          dec.o.vmax   = VMAX_W'(word[25:17] * AUG_VOLT_STEP);
          dec.o.vmin   = VMIN_W'(word[15:8] * AUG_VMIN_STEP);
          dec.need_div = word[25:17] != '0;
          dec.dividend = DIVIDEND_W'(word[7:0] * WATT_SCALE);
        end
        AUG_STD: begin
          dec.o.avs  = 1'b1;
          dec.o.vmin = ADJ_MIN_MV;
          if (word[9:0] != '0) begin
            dec.o.vmax = ADJ_HIGH_MV;
            dec.o.amp  = AMP_W'(word[9:0] * FIX_AMP_STEP);
          end else begin
            dec.o.vmax = ADJ_LOW_MV;
            dec.o.amp  = AMP_W'(word[19:10] * FIX_AMP_STEP);
          end
        end
        AUG_RSVD: begin
          dec = '0;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/pod_checker.sv
// port-level assertions for the power offer decoder, bound to the top level
`include "power_offer_decode_dedup_assert.svh"

module pod_checker
  import pod_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            outcome,
  input logic [SLOT_W-1:0]     slot,
  input logic [VMAX_W-1:0]     max_volt_mv,
  input logic [AMP_W-1:0]      max_amp_ma,
  input logic [CNT_W-1:0]      stored_count
);

  // a stalled result holds
  `POD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(outcome) && $stable(slot) && $stable(max_amp_ma),
    "result changed while stalled")

  // one request in flight at a time
  `POD_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
    "request taken while another is in work")

  // an ignored word reports no decoded fields
  `POD_ASSERT_NOW(a_beyond_zero, out_valid && outcome == OUT_BEYOND,
    slot == '0 && max_volt_mv == '0 && max_amp_ma == '0,
    "beyond-limit result carries decoded data")

  // a stored entry is a valid offer and counts in the table
  `POD_ASSERT_NOW(a_stored_valid, out_valid && outcome == OUT_STORED,
    stored_count != '0 && max_volt_mv != '0 && max_amp_ma != '0,
    "stored result is not a valid counted offer")

endmodule

bind power_offer_decode_dedup pod_checker u_checker (.*);
